### rtl/throttled_priority_notice_queue_defines.svh
// Assertion helpers shared by the notice queue modules.
// Both expect a signal named clock in the module that uses them; TPNQ_ASSERT also expects reset.
`ifndef THROTTLED_PRIORITY_NOTICE_QUEUE_DEFINES_SVH
`define THROTTLED_PRIORITY_NOTICE_QUEUE_DEFINES_SVH

// Checked only outside reset
`define TPNQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included
`define TPNQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/tpnq_pkg.sv
package tpnq_pkg;

   // Sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int ID_BITS     = 8;
   localparam int SEEN_DEPTH  = 1 << ID_BITS;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths
   localparam int ID_W       = 8;
   localparam int DUR_W      = 16;
   localparam int NOW_W      = 32;
   localparam int LIMIT_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = LIMIT_W'(3);
   localparam logic [CSR_DATA_W-1:0] COOLDOWN_RESET = CSR_DATA_W'(6000);
   localparam logic [CSR_DATA_W-1:0] LIFETIME_RESET = CSR_DATA_W'(2500);
   localparam logic [CSR_DATA_W-1:0] GAP_RESET      = CSR_DATA_W'(800);

   typedef logic [ID_BITS-1:0] slot_type;
   typedef logic [CNT_W-1:0]   count_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [DUR_W-1:0] dur;
      logic             urg;
   } notice_type;

   // Queue command word from the control logic
   typedef struct packed {
      logic       push_head;
      logic       push_tail;
      logic       pop;
      notice_type item;
   } q_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUEUE_LIMIT     = 3'd0,
      CSR_REPEAT_COOLDOWN = 3'd1,
      CSR_SHOW_LIFETIME   = 3'd2,
      CSR_MIN_GAP         = 3'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   // Seen-table index of an identifier
   function automatic slot_type slot_of(logic [ID_W-1:0] id);
      return slot_type'(id);
   endfunction

endpackage

### rtl/throttled_priority_notice_queue.sv
// Notice queue with repeat cooldown, lifetime and start spacing.
// Request channel (req_valid/req_stall): req_mode selects a push (0) carrying
// req_notice_id, req_show_time and req_urgent, or a tick (1). Every request
// carries req_now, the millisecond clock. Each request gives one response word
// on rsp_valid/rsp_stall: rsp_accepted for a push, or the showing notice
// (rsp_active_present, rsp_active_notice, rsp_active_time, rsp_active_urgent)
// for a tick.
// Each request passes the capture register, the seen-time memory read
// (ST_READ) and the decision/update state (ST_EXEC), which sets the response
// register. No new request is taken before ST_EXEC of the last one is done.
// A request may be taken while the previous response still waits; a stalled
// response holds the update cycle of the next request until it is taken.
// csr_write/csr_index/csr_wdata write the four settings; only write them
// while the block is idle. Unused indexes are ignored.
// Reset clears the queue, the showing notice, the start history and every
// seen-table valid bit at once; no clearing pass is needed.
module throttled_priority_notice_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [tpnq_pkg::ID_W-1:0]         req_notice_id,
   input  logic [tpnq_pkg::DUR_W-1:0]        req_show_time,
   input  logic                              req_urgent,
   input  logic [tpnq_pkg::NOW_W-1:0]        req_now,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_accepted,
   output logic                              rsp_active_present,
   output logic [tpnq_pkg::ID_W-1:0]         rsp_active_notice,
   output logic [tpnq_pkg::DUR_W-1:0]        rsp_active_time,
   output logic                              rsp_active_urgent,
   input  logic                              csr_write,
   input  logic [tpnq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tpnq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tpnq_pkg::*;

   state_type state_ff, state_in;

   // Settings
   logic [LIMIT_W-1:0]    limit_ff;
   logic [CSR_DATA_W-1:0] cooldown_ff, lifetime_ff, gap_ff;

   // Captured request
   logic             mode_ff;
   notice_type       item_ff;
   logic [NOW_W-1:0] now_ff;

   // Showing notice and start history
   logic             shown_valid_ff, shown_valid_in;
   notice_type       shown_ff, shown_in;
   logic [NOW_W-1:0] shown_start_ff, shown_start_in;
   logic [NOW_W-1:0] last_start_ff, last_start_in;
   logic             last_started_ff, last_started_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_accepted_ff, rsp_accepted_in;
   logic       rsp_present_ff, rsp_present_in;
   notice_type rsp_notice_ff, rsp_notice_in;

   // Queue and seen table
   q_cmd_type        q_cmd;
   count_type        q_count, eff_limit;
   notice_type       q_head;
   logic             q_dup;
   logic             seen_rd_valid;
   logic [NOW_W-1:0] seen_rd_time;
   logic             seen_wr_en;

   logic req_take, proceed;
   logic cool_hit, shown_hit, push_ok, gap_ok, promote, expire, preempt;

   tpnq_wait_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (q_cmd),
      .limit    (eff_limit),
      .probe_id (item_ff.id),
      .count    (q_count),
      .head     (q_head),
      .dup      (q_dup)
   );

   tpnq_seen_mem u_seen (
      .clock    (clock),
      .reset    (reset),
      .rd_slot  (slot_of(item_ff.id)),
      .rd_valid (seen_rd_valid),
      .rd_time  (seen_rd_time),
      .wr_en    (seen_wr_en),
      .wr_slot  (slot_of(q_head.id)),
      .wr_time  (now_ff)
   );

   // Limit saturates at the queue depth
   assign eff_limit = ((CNT_W + LIMIT_W)'(limit_ff) > (CNT_W + LIMIT_W)'(QUEUE_DEPTH)) ?
                      CNT_W'(QUEUE_DEPTH) : CNT_W'(limit_ff);

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      proceed   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            req_stall = 1'b1;
         end
         ST_EXEC: begin
            proceed = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_take = req_valid && !req_stall;

   // Push checks
   assign cool_hit  = seen_rd_valid &&
                      ((now_ff - seen_rd_time) < NOW_W'(cooldown_ff));
   assign shown_hit = shown_valid_ff && (shown_ff.id == item_ff.id);
   assign push_ok   = !cool_hit && !shown_hit && !q_dup &&
                      (item_ff.urg || (q_count < eff_limit));

   // Tick checks
   assign expire  = shown_valid_ff && ((now_ff - shown_start_ff) > NOW_W'(lifetime_ff));
   assign preempt = shown_valid_ff && !shown_ff.urg && (q_count != '0) && q_head.urg;
   assign gap_ok  = !last_started_ff || ((now_ff - last_start_ff) >= NOW_W'(gap_ff));
   assign promote = !shown_valid_ff && (q_count != '0) && gap_ok;

   // Datapath update
   always_comb begin
      shown_valid_in  = shown_valid_ff;
      shown_in        = shown_ff;
      shown_start_in  = shown_start_ff;
      last_start_in   = last_start_ff;
      last_started_in = last_started_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_notice_in   = rsp_notice_ff;
      q_cmd           = '0;
      q_cmd.item      = item_ff;
      seen_wr_en      = 1'b0;

      // Tick, read state: expiry and pre-emption
      if ((state_ff == ST_READ) && (mode_ff == MODE_TICK)) begin
         if (expire || preempt) begin
            shown_valid_in = 1'b0;
         end
      end

      // Exec state: decision and response
      if (proceed) begin
         rsp_valid_in = 1'b1;
         if (mode_ff == MODE_PUSH) begin
            q_cmd.push_head = push_ok && item_ff.urg;
            q_cmd.push_tail = push_ok && !item_ff.urg;
            rsp_accepted_in = push_ok;
            rsp_present_in  = 1'b0;
            rsp_notice_in   = '0;
         end else begin
            rsp_accepted_in = 1'b0;
            rsp_present_in  = shown_valid_ff || promote;
            rsp_notice_in   = shown_valid_ff ? shown_ff : '0;
            if (promote) begin
               q_cmd.pop       = 1'b1;
               seen_wr_en      = 1'b1;
               shown_valid_in  = 1'b1;
               shown_in        = q_head;
               shown_start_in  = now_ff;
               last_start_in   = now_ff;
               last_started_in = 1'b1;
               rsp_notice_in   = q_head;
            end
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff      <= req_mode;
         item_ff.id   <= req_notice_id;
         item_ff.dur  <= req_show_time;
         item_ff.urg  <= req_urgent;
         now_ff       <= req_now;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_notice_ff   <= rsp_notice_in;
   end

   // Control state and settings
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         shown_valid_ff  <= 1'b0;
         shown_ff        <= '0;
         shown_start_ff  <= '0;
         last_start_ff   <= '0;
         last_started_ff <= 1'b0;
         limit_ff        <= LIMIT_RESET;
         cooldown_ff     <= COOLDOWN_RESET;
         lifetime_ff     <= LIFETIME_RESET;
         gap_ff          <= GAP_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         shown_valid_ff  <= shown_valid_in;
         shown_ff        <= shown_in;
         shown_start_ff  <= shown_start_in;
         last_start_ff   <= last_start_in;
         last_started_ff <= last_started_in;
         if (csr_write) begin
            case (csr_index)
               CSR_QUEUE_LIMIT:     limit_ff    <= csr_wdata[LIMIT_W-1:0];
               CSR_REPEAT_COOLDOWN: cooldown_ff <= csr_wdata;
               CSR_SHOW_LIFETIME:   lifetime_ff <= csr_wdata;
               CSR_MIN_GAP:         gap_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_active_present = rsp_present_ff;
   assign rsp_active_notice  = rsp_notice_ff.id;
   assign rsp_active_time    = rsp_notice_ff.dur;
   assign rsp_active_urgent  = rsp_notice_ff.urg;

`include "throttled_priority_notice_queue_defines.svh"

   `TPNQ_ASSERT(a_take_reads, req_take |=> state_ff == ST_READ, "request not followed by read")
   `TPNQ_ASSERT(a_push_word, rsp_valid_ff && rsp_accepted_ff |-> !rsp_present_ff,
                "push word carries a showing notice")
   `TPNQ_ASSERT(a_empty_tick, rsp_valid_ff && !rsp_present_ff |-> rsp_notice_ff == '0,
                "tick word shows fields with nothing showing")
   `TPNQ_ASSERT(a_promote_shows,
                promote && proceed && (mode_ff == MODE_TICK) |=> shown_valid_ff && last_started_ff,
                "promotion did not start a notice")

endmodule

### rtl/tpnq_seen_mem.sv
module tpnq_seen_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  tpnq_pkg::slot_type        rd_slot,
   output logic                      rd_valid,
   output logic [tpnq_pkg::NOW_W-1:0] rd_time,
   input  logic                      wr_en,
   input  tpnq_pkg::slot_type        wr_slot,
   input  logic [tpnq_pkg::NOW_W-1:0] wr_time
);
   import tpnq_pkg::*;

   logic [NOW_W-1:0] time_mem [SEEN_DEPTH];
   logic [SEEN_DEPTH-1:0] valid_ff;
   logic [NOW_W-1:0] rd_time_ff;
   logic rd_valid_ff;

   // Time store: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_slot] <= wr_time;
      end
      rd_time_ff <= time_mem[rd_slot];
   end

   // Valid bit per slot, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_slot] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_slot];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_time  = rd_time_ff;

endmodule

### rtl/tpnq_wait_queue.sv
module tpnq_wait_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  tpnq_pkg::q_cmd_type     cmd,
   input  tpnq_pkg::count_type     limit,
   input  logic [tpnq_pkg::ID_W-1:0] probe_id,
   output tpnq_pkg::count_type     count,
   output tpnq_pkg::notice_type    head,
   output logic                    dup
);
   import tpnq_pkg::*;

   notice_type entry_ff [QUEUE_DEPTH];
   notice_type entry_in [QUEUE_DEPTH];
   count_type  count_ff, count_in;
   count_type  top;
   logic [QUEUE_DEPTH-1:0] hit;

   // Duplicate scan over the live entries
   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         hit[k] = (CNT_W'(k) < count_ff) && (entry_ff[k].id == probe_id);
      end
   end

   assign dup   = |hit;
   assign head  = entry_ff[0];
   assign count = count_ff;

   // Insert at head, append at tail, or pop the head
   always_comb begin
      top      = (count_ff >= CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH - 1) : count_ff;
      entry_in = entry_ff;
      count_in = count_ff;
      if (cmd.push_head) begin
         for (int k = 1; k < QUEUE_DEPTH; k++) begin
            entry_in[k] = entry_ff[k-1];
         end
         entry_in[0] = cmd.item;
         count_in    = ((top + 1'b1) > limit) ? limit : (top + 1'b1);
      end else if (cmd.push_tail) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (CNT_W'(k) == count_ff) begin
               entry_in[k] = cmd.item;
            end
         end
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            entry_in[k] = entry_ff[k+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`include "throttled_priority_notice_queue_defines.svh"

   `TPNQ_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `TPNQ_ASSERT(a_pop_nonempty, cmd.pop |-> count_ff != '0, "pop from an empty queue")
   `TPNQ_ASSERT(a_tail_room, cmd.push_tail |=> count_ff == $past(count_ff) + 1'b1,
                "append did not grow the queue")

endmodule
